### sv/shwg_pkg.sv
package shwg_pkg;

	// one turn in millidegrees
	localparam logic [18:0] FULL_TURN = 19'd360000;
	localparam logic [18:0] HALF_TURN = 19'd180000;
	localparam logic [19:0] TWO_TURNS = 20'd720000;

	// advance table breakpoints, rpm
	localparam logic [11:0] ADV_X1 = 12'd1375;
	localparam logic [11:0] ADV_X2 = 12'd1750;
	localparam logic [11:0] ADV_X3 = 12'd2125;
	localparam logic [11:0] ADV_X4 = 12'd2500;

	// steer trim: 100 - trunc((steer + 1000) / 10)
	localparam logic [11:0] STEER_OFS = 12'd1000;
	localparam logic [8:0]  TRIM_BIAS = 9'd100;

	// reciprocals for constant division: floor(x / d) = (x * m) >> k
	localparam int          PER_SHIFT   = 34;
	localparam logic [29:0] PER_RECIP   = 30'(((64'd1 << 34) + 64'd24) / 64'd25);
	localparam int          TEN_SHIFT   = 15;
	localparam logic [11:0] TEN_RECIP   = 12'(((64'd1 << 15) + 64'd9) / 64'd10);
	localparam int          ADV_SHIFT_LONG  = 41;
	localparam logic [30:0] ADV_RECIP_LONG  = 31'(((64'd1 << 41) + 64'd1374) / 64'd1375);
	localparam int          ADV_SHIFT_SHORT = 39;
	localparam logic [30:0] ADV_RECIP_SHORT = 31'(((64'd1 << 39) + 64'd374) / 64'd375);
	localparam int          GAP_SHIFT   = 31;
	localparam logic [24:0] GAP_RECIP   = 25'(((64'd1 << 31) + 64'd124) / 64'd125);
	localparam int          TURN_SHIFT  = 43;
	localparam logic [30:0] TURN_RECIP  = 31'(((64'd1 << 43) + 64'd5624) / 64'd5625);

	// configuration reset values
	localparam logic [18:0] LED_WIDTH_RST = 19'd40000;
	localparam logic [18:0] MIN_PULSE_RST = 19'd25000;
	localparam logic [18:0] MAX_PULSE_RST = 19'd100000;
	localparam logic [15:0] MAX_GAP_RST   = 16'd150;

	typedef enum logic [2:0] {
		REG_LED_WIDTH,
		REG_ADV_ONE,
		REG_ADV_TWO,
		REG_ADV_THREE,
		REG_ADV_FOUR,
		REG_MIN_PULSE,
		REG_MAX_PULSE,
		REG_MAX_GAP
	} cfg_reg_t;

	typedef struct packed {
		logic [18:0] led_width;
		logic [18:0] adv_one;
		logic [18:0] adv_two;
		logic [18:0] adv_three;
		logic [18:0] adv_four;
		logic [18:0] min_pulse;
		logic [18:0] max_pulse;
		logic [15:0] max_gap;
	} cfg_t;

	// per-request context handed from the arc pipeline to the tracker
	typedef struct packed {
		logic [18:0]        step;
		logic [31:0]        time_us;
		logic [31:0]        time_ms;
		logic               trans_nz;
		logic [24:0]        trim_lim;
		logic signed [7:0]  trim;
		logic [15:0]        gap;
		logic [18:0]        arc_start;
		logic [18:0]        arc_end;
	} arc_t;

endpackage

### sv/shwg_if.sv
interface shwg_item_if;
	logic               valid;
	logic               ready;
	logic [18:0]        angle_step;
	logic [31:0]        period_us;
	logic [31:0]        time_us;
	logic [31:0]        time_ms;
	logic [15:0]        speed_rpm;
	logic signed [10:0] steer;
	logic signed [10:0] translate;

	modport source (
		output valid, angle_step, period_us, time_us, time_ms, speed_rpm, steer, translate,
		input  ready
	);
	modport sink (
		input  valid, angle_step, period_us, time_us, time_ms, speed_rpm, steer, translate,
		output ready
	);
endinterface

interface shwg_result_if;
	logic        valid;
	logic        ready;
	logic        led_on;
	logic        window_active;
	logic        brake_drive;
	logic [18:0] heading;

	modport source (
		output valid, led_on, window_active, brake_drive, heading,
		input  ready
	);
	modport sink (
		input  valid, led_on, window_active, brake_drive, heading,
		output ready
	);
endinterface

### sv/shwg_cfg_regs.sv
module shwg_cfg_regs
	import shwg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wen,
	input  logic [2:0]  index,
	input  logic [18:0] data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_width <= LED_WIDTH_RST;
			cfg_q.adv_one   <= '0;
			cfg_q.adv_two   <= '0;
			cfg_q.adv_three <= '0;
			cfg_q.adv_four  <= '0;
			cfg_q.min_pulse <= MIN_PULSE_RST;
			cfg_q.max_pulse <= MAX_PULSE_RST;
			cfg_q.max_gap   <= MAX_GAP_RST;
		end else if (wen) begin
			case (cfg_reg_t'(index))
				REG_LED_WIDTH: cfg_q.led_width <= data;
				REG_ADV_ONE:   cfg_q.adv_one   <= data;
				REG_ADV_TWO:   cfg_q.adv_two   <= data;
				REG_ADV_THREE: cfg_q.adv_three <= data;
				REG_ADV_FOUR:  cfg_q.adv_four  <= data;
				REG_MIN_PULSE: cfg_q.min_pulse <= data;
				REG_MAX_PULSE: cfg_q.max_pulse <= data;
				REG_MAX_GAP:   cfg_q.max_gap   <= data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/shwg_arc_pipe.sv
module shwg_arc_pipe
	import shwg_pkg::*;
#(
	parameter int MAX_RPM = 3500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	shwg_item_if.sink   item,
	input  logic        take,
	output logic        arc_vld,
	output arc_t        arc
);

	// pulse width divide by MAX_RPM; dividend is below 2^35
	localparam int          WID_SHIFT = 35 + $clog2(MAX_RPM);
	localparam logic [36:0] WID_RECIP =
		37'(((64'd1 << WID_SHIFT) + 64'(MAX_RPM) - 64'd1) / 64'(MAX_RPM));

	logic [8:1] vld_q;
	logic [9:1] rdy;
	logic [8:1] vld_in;

	// stage 1: request register
	logic [18:0]        step_s1;
	logic [31:0]        period_s1;
	logic [31:0]        tus_s1;
	logic [31:0]        tms_s1;
	logic [15:0]        rpm_s1;
	logic signed [10:0] steer_s1;
	logic signed [10:0] trans_s1;

	// stage 2
	arc_t        arc_s2;
	logic [34:0] wprod_s2;
	logic        wneg_s2;
	logic [29:0] pa_s2;
	logic [29:0] pb_s2;
	logic        along_s2;
	logic        ahold_s2;
	logic [26:0] gprod_s2;
	logic        tneg_s2;

	// stage 3
	arc_t        arc_s3;
	logic [52:0] pp_lo_s3;
	logic [53:0] pp_hi_s3;
	logic        wneg_s3;
	logic [29:0] anum_s3;
	logic        along_s3;
	logic        ahold_s3;
	logic [16:0] gq_s3;
	logic        tneg_s3;

	// stage 4
	arc_t        arc_s4;
	logic [34:0] qm_s4;
	logic        wneg_s4;
	logic [18:0] aq_s4;
	logic        tneg_s4;

	// stage 5
	arc_t        arc_s5;
	logic [35:0] w_s5;
	logic [18:0] st0_s5;
	logic        tneg_s5;

	// stage 6
	arc_t        arc_s6;
	logic [35:0] w_s6;
	logic [17:0] wq_s6;
	logic [18:0] start_s6;

	// stage 7
	arc_t        arc_s7;
	logic [18:0] wm_s7;
	logic [18:0] start_s7;

	// stage 8
	arc_t        arc_s8;

	// ---- handshake: each stage loads when empty or moving on
	always_comb begin
		rdy[9] = take;
		for (int k = 8; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_in     = {vld_q[7:1], item.valid};
	assign item.ready = rdy[1];
	assign arc_vld    = vld_q[8];
	assign arc        = arc_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= 8; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// ---- stage 1 -> 2
	logic [58:0] per_prod;
	logic [11:0] steer_ofs;
	logic [10:0] steer_mag;
	logic [22:0] ten_prod;
	logic [7:0]  ten_q;
	logic [8:0]  trim_sum;
	logic [19:0] pw_diff;
	logic [18:0] pw_mag;
	logic [18:0] adv_ylo;
	logic [18:0] adv_yhi;
	logic [11:0] adv_xlo;
	logic [11:0] adv_xhi;
	logic        adv_long;
	logic [10:0] adv_da;
	logic [10:0] adv_db;
	logic [10:0] trans_mag;
	arc_t        arc_in;

	assign per_prod  = 59'(period_s1[31:3]) * 59'(PER_RECIP);
	assign steer_ofs = {steer_s1[10], steer_s1} + STEER_OFS;
	assign steer_mag = steer_ofs[11] ? 11'(12'd0 - steer_ofs) : steer_ofs[10:0];
	assign ten_prod  = 23'(steer_mag) * 23'(TEN_RECIP);
	assign ten_q     = 8'(ten_prod >> TEN_SHIFT);
	assign trim_sum  = steer_ofs[11] ? TRIM_BIAS + 9'(ten_q) : TRIM_BIAS - 9'(ten_q);

	assign pw_diff = {1'b0, cfg.max_pulse} - {1'b0, cfg.min_pulse};
	assign pw_mag  = pw_diff[19] ? 19'(20'd0 - pw_diff) : pw_diff[18:0];

	assign trans_mag = trans_s1[10] ? 11'(12'd0 - {trans_s1[10], trans_s1}) : trans_s1[10:0];

	always_comb begin
		if (rpm_s1 < 16'(ADV_X1)) begin
			adv_ylo  = '0;
			adv_yhi  = cfg.adv_one;
			adv_xlo  = '0;
			adv_xhi  = ADV_X1;
			adv_long = 1'b1;
		end else if (rpm_s1 < 16'(ADV_X2)) begin
			adv_ylo  = cfg.adv_one;
			adv_yhi  = cfg.adv_two;
			adv_xlo  = ADV_X1;
			adv_xhi  = ADV_X2;
			adv_long = 1'b0;
		end else if (rpm_s1 < 16'(ADV_X3)) begin
			adv_ylo  = cfg.adv_two;
			adv_yhi  = cfg.adv_three;
			adv_xlo  = ADV_X2;
			adv_xhi  = ADV_X3;
			adv_long = 1'b0;
		end else begin
			adv_ylo  = cfg.adv_three;
			adv_yhi  = cfg.adv_four;
			adv_xlo  = ADV_X3;
			adv_xhi  = ADV_X4;
			adv_long = 1'b0;
		end
		// at or above the last breakpoint the distances are don't-care
		adv_da = 11'(adv_xhi - rpm_s1[11:0]);
		adv_db = 11'(rpm_s1[11:0] - adv_xlo);
	end

	always_comb begin
		arc_in           = '0;
		arc_in.step      = step_s1;
		arc_in.time_us   = tus_s1;
		arc_in.time_ms   = tms_s1;
		arc_in.trans_nz  = (trans_s1 != 11'sd0);
		arc_in.trim_lim  = 25'(per_prod >> PER_SHIFT);
		arc_in.trim      = 8'(trim_sum);
	end

	// ---- stage 2 -> 3
	logic [52:0] pp_lo_n;
	logic [53:0] pp_hi_n;
	logic [48:0] gap_prod;

	assign pp_lo_n  = 53'(wprod_s2) * 53'(WID_RECIP[17:0]);
	assign pp_hi_n  = 54'(wprod_s2) * 54'(WID_RECIP[36:18]);
	assign gap_prod = 49'(gprod_s2[26:3]) * 49'(GAP_RECIP);

	// ---- stage 3 -> 4
	logic [72:0] wsum;
	logic [30:0] adv_m;
	logic [60:0] adv_prod;
	logic [18:0] aq_n;
	logic [15:0] gap_n;
	arc_t        arc_gap_n;

	assign wsum     = (73'(pp_hi_s3) << 18) + 73'(pp_lo_s3);
	assign adv_m    = along_s3 ? ADV_RECIP_LONG : ADV_RECIP_SHORT;
	assign adv_prod = 61'(anum_s3) * 61'(adv_m);

	always_comb begin
		if (ahold_s3) begin
			aq_n = cfg.adv_four;
		end else if (along_s3) begin
			aq_n = 19'(adv_prod >> ADV_SHIFT_LONG);
		end else begin
			aq_n = 19'(adv_prod >> ADV_SHIFT_SHORT);
		end
		gap_n = ({1'b0, cfg.max_gap} > gq_s3) ? cfg.max_gap - 16'(gq_s3) : '0;
		arc_gap_n     = arc_s3;
		arc_gap_n.gap = gap_n;
	end

	// ---- stage 4 -> 5
	logic [35:0] min36;
	logic [35:0] qm36;
	logic [35:0] w_n;
	logic [18:0] st0_n;

	assign min36 = 36'(cfg.min_pulse);
	assign qm36  = 36'(qm_s4);

	always_comb begin
		if (wneg_s4) begin
			w_n = (min36 >= qm36) ? min36 - qm36 : '0;
		end else begin
			w_n = min36 + qm36;
		end
		// start = (turn - advance mod turn) mod turn
		if (aq_s4 == '0 || aq_s4 == FULL_TURN) begin
			st0_n = '0;
		end else if (aq_s4 < FULL_TURN) begin
			st0_n = FULL_TURN - aq_s4;
		end else begin
			st0_n = 19'(TWO_TURNS - {1'b0, aq_s4});
		end
	end

	// ---- stage 5 -> 6
	logic [60:0] wdiv;
	logic [18:0] start_n;

	assign wdiv = 61'(w_s5[35:6]) * 61'(TURN_RECIP);

	always_comb begin
		if (!tneg_s5) begin
			start_n = st0_s5;
		end else if (st0_s5 >= HALF_TURN) begin
			start_n = st0_s5 - HALF_TURN;
		end else begin
			start_n = st0_s5 + HALF_TURN;
		end
	end

	// ---- stage 7 -> 8
	logic [19:0] esum;
	logic [18:0] end_n;
	arc_t        arc_fin_n;

	assign esum  = {1'b0, start_s7} + {1'b0, wm_s7};
	assign end_n = (esum >= {1'b0, FULL_TURN}) ? 19'(esum - {1'b0, FULL_TURN}) : esum[18:0];

	always_comb begin
		arc_fin_n           = arc_s7;
		arc_fin_n.arc_start = start_s7;
		arc_fin_n.arc_end   = end_n;
	end

	// ---- pipeline registers
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			step_s1   <= item.angle_step;
			period_s1 <= item.period_us;
			tus_s1    <= item.time_us;
			tms_s1    <= item.time_ms;
			rpm_s1    <= item.speed_rpm;
			steer_s1  <= item.steer;
			trans_s1  <= item.translate;
		end
		if (rdy[2]) begin
			arc_s2   <= arc_in;
			wprod_s2 <= 35'(rpm_s1) * 35'(pw_mag);
			wneg_s2  <= pw_diff[19];
			pa_s2    <= 30'(adv_ylo) * 30'(adv_da);
			pb_s2    <= 30'(adv_yhi) * 30'(adv_db);
			along_s2 <= adv_long;
			ahold_s2 <= (rpm_s1 >= 16'(ADV_X4));
			gprod_s2 <= 27'(trans_mag) * 27'(cfg.max_gap);
			tneg_s2  <= trans_s1[10];
		end
		if (rdy[3]) begin
			arc_s3   <= arc_s2;
			pp_lo_s3 <= pp_lo_n;
			pp_hi_s3 <= pp_hi_n;
			wneg_s3  <= wneg_s2;
			anum_s3  <= pa_s2 + pb_s2;
			along_s3 <= along_s2;
			ahold_s3 <= ahold_s2;
			gq_s3    <= 17'(gap_prod >> GAP_SHIFT);
			tneg_s3  <= tneg_s2;
		end
		if (rdy[4]) begin
			arc_s4     <= arc_gap_n;
			qm_s4      <= 35'(wsum >> WID_SHIFT);
			wneg_s4    <= wneg_s3;
			aq_s4      <= aq_n;
			tneg_s4    <= tneg_s3;
		end
		if (rdy[5]) begin
			arc_s5  <= arc_s4;
			w_s5    <= w_n;
			st0_s5  <= st0_n;
			tneg_s5 <= tneg_s4;
		end
		if (rdy[6]) begin
			arc_s6   <= arc_s5;
			w_s6     <= w_s5;
			wq_s6    <= 18'(wdiv >> TURN_SHIFT);
			start_s6 <= start_n;
		end
		if (rdy[7]) begin
			arc_s7   <= arc_s6;
			wm_s7    <= 19'(w_s6 - 36'(wq_s6) * 36'(FULL_TURN));
			start_s7 <= start_s6;
		end
		if (rdy[8]) begin
			arc_s8 <= arc_fin_n;
		end
	end

endmodule

### sv/shwg_track.sv
module shwg_track
	import shwg_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          arc_vld,
	input  arc_t          arc,
	output logic          take,
	shwg_result_if.source result
);

	logic [18:0] heading_q;
	logic [31:0] last_trim_q;
	logic [31:0] last_fire_q;
	logic        chop_q;
	logic        prior_q;
	logic        res_vld_q;
	logic        led_q;
	logic        win_q;
	logic        brake_q;

	function automatic logic [18:0] wrap_turn(input logic signed [20:0] v);
		logic signed [20:0] turn;
		logic signed [20:0] r;
		turn = $signed({2'b00, FULL_TURN});
		if (v < 0) begin
			r = v + turn;
		end else if (v >= (turn <<< 1)) begin
			r = v - (turn <<< 1);
		end else if (v >= turn) begin
			r = v - turn;
		end else begin
			r = v;
		end
		return r[18:0];
	endfunction

	logic               fire;
	logic [31:0]        elapsed_us;
	logic               trim_en;
	logic signed [20:0] base_plain;
	logic signed [20:0] base_trim;
	logic [18:0]        h;
	logic [18:0]        led_half;
	logic [18:0]        led_lim;
	logic               led;
	logic               in_arc;
	logic [31:0]        elapsed_ms;
	logic               gap_open;
	logic               act;
	logic               chop_n;
	logic               prior_n;
	logic               stamp;

	assign take = !res_vld_q || result.ready;
	assign fire = arc_vld && take;

	assign elapsed_us = arc.time_us - last_trim_q;
	assign trim_en    = elapsed_us > 32'(arc.trim_lim);
	assign base_plain = $signed({2'b00, heading_q} + {2'b00, arc.step});
	assign base_trim  = base_plain + $signed({{13{arc.trim[7]}}, arc.trim});
	assign h          = trim_en ? wrap_turn(base_trim) : wrap_turn(base_plain);

	assign led_half = {1'b0, cfg.led_width[18:1]};
	assign led_lim  = FULL_TURN - led_half;
	assign led      = (h > led_lim) || (h < led_half);

	// arc that wraps past zero (or has equal ends, a full circle) opens across the seam
	assign in_arc = (arc.arc_start < arc.arc_end) ?
		((h >= arc.arc_start) && (h < arc.arc_end)) :
		((h >= arc.arc_start) || (h < arc.arc_end));

	assign elapsed_ms = arc.time_ms - last_fire_q;
	assign gap_open   = elapsed_ms >= 32'(arc.gap);

	always_comb begin
		act     = 1'b0;
		chop_n  = chop_q;
		prior_n = in_arc;
		stamp   = 1'b0;
		if (gap_open) begin
			// a window already open when the gap runs out is skipped
			if (!(in_arc && chop_q)) begin
				chop_n = 1'b0;
				act    = in_arc;
			end
			if (!chop_n && (prior_q != act) && !act) begin
				chop_n = 1'b1;
				stamp  = 1'b1;
			end
			prior_n = act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q   <= '0;
			last_trim_q <= '0;
			last_fire_q <= '0;
			chop_q      <= 1'b1;
			prior_q     <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			if (take) begin
				res_vld_q <= arc_vld;
			end
			if (fire) begin
				heading_q <= h;
				chop_q    <= chop_n;
				prior_q   <= prior_n;
				if (trim_en) begin
					last_trim_q <= arc.time_us;
				end
				if (stamp) begin
					last_fire_q <= arc.time_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_q   <= led;
			win_q   <= act;
			brake_q <= act && arc.trans_nz;
		end
	end

	assign result.valid         = res_vld_q;
	assign result.led_on        = led_q;
	assign result.window_active = win_q;
	assign result.brake_drive   = brake_q;
	assign result.heading       = heading_q;

endmodule

### sv/spin_heading_window_gate_unit.sv
// A request passes the request register, the arc stages and the tracker to the result channel.
// One request per cycle unless result.ready stalls it; eight arc stages run ahead of a tracker
// that holds heading, trim time, fire time and the activation guard.
// The pulse-width divide, its wrap to one turn and the arc end set the pipeline depth.
// Reset (arst_n low): configuration to its reset values, heading and timers to zero,
// guard set, pipeline and result register empty; requests are taken right after reset.
module spin_heading_window_gate_unit
	import shwg_pkg::*;
#(
	parameter int MAX_RPM = 3500
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [2:0]    cfg_index,
	input  logic [18:0]   cfg_data,
	shwg_item_if.sink     item,
	shwg_result_if.source result
);

	cfg_t cfg;
	arc_t arc;
	logic arc_vld;
	logic take;

	shwg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	shwg_arc_pipe #(
		.MAX_RPM (MAX_RPM)
	) u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item),
		.take    (take),
		.arc_vld (arc_vld),
		.arc     (arc)
	);

	shwg_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.arc_vld (arc_vld),
		.arc     (arc),
		.take    (take),
		.result  (result)
	);

endmodule

### verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import shwg_pkg::*;

	localparam int     SPIN_MAX_RPM = 3500;
	localparam int     CYCLE_LIMIT  = 300000;
	localparam int     PASSES_PER_PHASE = 90;
	localparam longint TURN = FULL_TURN;
	localparam longint HALF = HALF_TURN;

	typedef struct packed {
		logic [18:0]        angle_step;
		logic [31:0]        period_us;
		logic [31:0]        time_us;
		logic [31:0]        time_ms;
		logic [15:0]        speed_rpm;
		logic signed [10:0] steer;
		logic signed [10:0] translate;
	} pass_t;

	typedef struct packed {
		logic        led_on;
		logic        window_active;
		logic        brake_drive;
		logic [18:0] heading;
	} gate_t;

	typedef struct packed {
		pass_t p;
		logic  fixed;
		gate_t want;
	} row_t;

	// first two rows are fresh out of reset with reset registers: arc [0, 25000),
	// gap of 150 ms not yet run, so the window stays closed
	localparam row_t DIRECTED_ROWS [20] = '{
		'{'{19'd0, 32'd0, 32'd0, 32'd0, 16'd0, 11'sd0, 11'sd0}, 1'b1,
			'{1'b1, 1'b0, 1'b0, 19'd0}},
		'{'{19'd359999, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 11'sd0, 11'sd0}, 1'b1,
			'{1'b1, 1'b0, 1'b0, 19'd359999}},
		'{'{19'd0, 32'd0, 32'd1, 32'd0, 16'd0, 11'sh400, 11'sd0}, 1'b0, '0},
		'{'{19'd0, 32'd0, 32'd2, 32'd0, 16'd0, 11'sd1023, 11'sd0}, 1'b0, '0},
		'{'{19'd0, 32'd0, 32'd3, 32'd10, 16'd0, -11'sd1000, 11'sd0}, 1'b0, '0},
		'{'{19'd0, 32'd0, 32'd4, 32'd20, 16'd0, 11'sd1000, 11'sd0}, 1'b0, '0},
		'{'{19'd1000, 32'hFFFF_FFFF, 32'd5, 32'd150, 16'd0, 11'sd0, 11'sd0}, 1'b0, '0},
		'{'{19'd20000, 32'd1000, 32'd9, 32'd151, 16'd1375, 11'sd0, 11'sd1000}, 1'b0, '0},
		'{'{19'd90000, 32'd1000, 32'd20, 32'd152, 16'd1750, 11'sd5, -11'sd1000}, 1'b0, '0},
		'{'{19'd60000, 32'd0, 32'd30, 32'd400, 16'd2125, -11'sd5, 11'sh400}, 1'b0, '0},
		'{'{19'd60000, 32'd0, 32'd40, 32'd401, 16'd2500, 11'sd0, 11'sd1023}, 1'b0, '0},
		'{'{19'd60000, 32'd0, 32'd50, 32'd700, 16'd65535, 11'sd0, 11'sd500}, 1'b0, '0},
		'{'{19'd45000, 32'd0, 32'd60, 32'd900, 16'd3499, 11'sd0, -11'sd1}, 1'b0, '0},
		'{'{19'd359999, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd3500, -11'sd1, 11'sd1},
			1'b0, '0},
		'{'{19'd180000, 32'd7, 32'd0, 32'd0, 16'd1, 11'sd1, 11'sd0}, 1'b0, '0},
		'{'{19'd12345, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd1374, 11'sd999,
			11'sd999}, 1'b0, '0},
		'{'{19'd30000, 32'd200, 32'h8000_0001, 32'h8000_0100, 16'd2499, -11'sd999,
			-11'sd999}, 1'b0, '0},
		'{'{19'd30000, 32'd200, 32'h8000_0002, 32'h8000_0200, 16'd4000, 11'sd0, 11'sd0},
			1'b0, '0},
		'{'{19'h7FFFF, 32'd0, 32'h8000_0003, 32'h8000_0300, 16'd2000, 11'sd0, 11'sd0},
			1'b0, '0},
		'{'{19'd5000, 32'd0, 32'h8000_0004, 32'h8000_0400, 16'd0, 11'sd0, -11'sd1000},
			1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [2:0] cfg_index;
	logic [18:0] cfg_data;

	shwg_item_if   item_ch ();
	shwg_result_if result_ch ();

	spin_heading_window_gate_unit #(
		.MAX_RPM(SPIN_MAX_RPM)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(result_ch)
	);

	// mirror of the block: registers and tracker state
	logic [18:0] reg_val [8];
	logic [18:0] hdg;
	logic [31:0] trim_stamp_us;
	logic [31:0] fire_stamp_ms;
	logic        guard_armed;
	logic        arc_was_open;

	gate_t gate_results_due [$];
	int    bad_fields = 0;
	int    cycles = 0;
	bit    calm = 1'b0;
	logic  drv_fixed;
	gate_t drv_want;
	logic [31:0] clock_us;
	logic [31:0] clock_ms;
	int    random_sent = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic longint advance_at(longint rpm);
		longint xs [5];
		longint ys [5];
		int i;
		xs[0] = 0;
		xs[1] = ADV_X1;
		xs[2] = ADV_X2;
		xs[3] = ADV_X3;
		xs[4] = ADV_X4;
		ys[0] = 0;
		ys[1] = reg_val[REG_ADV_ONE];
		ys[2] = reg_val[REG_ADV_TWO];
		ys[3] = reg_val[REG_ADV_THREE];
		ys[4] = reg_val[REG_ADV_FOUR];
		if (rpm <= 0)
			return 0;
		if (rpm >= xs[4])
			return ys[4];
		i = 0;
		while (i < 3 && rpm >= xs[i + 1])
			i++;
		return (ys[i] * (xs[i + 1] - rpm) + ys[i + 1] * (rpm - xs[i])) / (xs[i + 1] - xs[i]);
	endfunction

	function automatic gate_t heading_gate_pass(pass_t p);
		longint step, h, half, width, start, stop, gap, mag, rpm, steer_v, trans_v;
		logic [31:0] dt_us, dt_ms;
		logic lit, open;
		gate_t r;
		step = p.angle_step;
		rpm = p.speed_rpm;
		steer_v = longint'($signed(p.steer));
		trans_v = longint'($signed(p.translate));

		dt_us = p.time_us - trim_stamp_us;
		if (dt_us > p.period_us / 200) begin
			step += (steer_v + 1000) * (-200) / 2000 + 100;
			trim_stamp_us = p.time_us;
		end

		h = (longint'(hdg) + step) % TURN;
		if (h < 0)
			h += TURN;
		hdg = h[18:0];

		half = reg_val[REG_LED_WIDTH] / 2;
		lit = (h > TURN - half) || (h < half);

		width = rpm * (longint'(reg_val[REG_MAX_PULSE]) - longint'(reg_val[REG_MIN_PULSE]))
			/ SPIN_MAX_RPM + longint'(reg_val[REG_MIN_PULSE]);
		if (width < 0)
			width = 0;
		start = (TURN - (advance_at(rpm) % TURN)) % TURN;
		if (trans_v < 0)
			start = (start + HALF) % TURN;
		stop = (start + width) % TURN;
		// equal ends mean a full circle, open everywhere
		if (start < stop)
			open = (h >= start) && (h < stop);
		else
			open = (h >= start) || (h < stop);

		mag = trans_v < 0 ? -trans_v : trans_v;
		gap = longint'(reg_val[REG_MAX_GAP]) - mag * longint'(reg_val[REG_MAX_GAP]) / 1000;
		if (gap < 0)
			gap = 0;
		dt_ms = p.time_ms - fire_stamp_ms;
		if (longint'(dt_ms) >= gap) begin
			// a window already open when the gap runs out is skipped whole
			if (open && guard_armed)
				open = 1'b0;
			else
				guard_armed = 1'b0;
			if (!guard_armed && arc_was_open != open && !open) begin
				guard_armed = 1'b1;
				fire_stamp_ms = p.time_ms;
			end
			arc_was_open = open;
		end else begin
			arc_was_open = open;
			open = 1'b0;
		end

		r.led_on = lit;
		r.window_active = open;
		r.brake_drive = open && (trans_v != 0);
		r.heading = hdg;
		return r;
	endfunction

	function automatic logic signed [10:0] stick_value(int zero_weight);
		int pick;
		pick = $urandom_range(19);
		if (pick < zero_weight)
			return 11'sd0;
		if (pick == 19)
			return 11'sh400;
		if (pick == 18)
			return 11'sd1023;
		return 11'(int'($urandom_range(0, 2000)) - 1000);
	endfunction

	// mostly a spinning robot with clocks moving forward, some pure noise
	function automatic pass_t next_pass();
		pass_t p;
		if ($urandom_range(99) < 10) begin
			p.angle_step = 19'($urandom_range(0, 19'h7FFFF));
			p.period_us = $urandom;
			p.time_us = $urandom;
			p.time_ms = $urandom;
			p.speed_rpm = 16'($urandom);
			p.steer = 11'($urandom);
			p.translate = 11'($urandom);
		end else begin
			clock_us += $urandom_range(50, 3000);
			clock_ms += $urandom_range(0, 25);
			p.angle_step = ($urandom_range(15) == 0) ? 19'($urandom_range(0, 359999))
				: 19'($urandom_range(0, 45000));
			p.period_us = $urandom_range(1000, 200000);
			p.time_us = clock_us;
			p.time_ms = clock_ms;
			p.speed_rpm = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
			p.steer = stick_value(2);
			p.translate = stick_value(5);
		end
		return p;
	endfunction

	task automatic send_pass(pass_t p, logic fixed, gate_t want);
		while (!calm && $urandom_range(99) < 19) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.angle_step <= p.angle_step;
		item_ch.period_us <= p.period_us;
		item_ch.time_us <= p.time_us;
		item_ch.time_ms <= p.time_ms;
		item_ch.speed_rpm <= p.speed_rpm;
		item_ch.steer <= p.steer;
		item_ch.translate <= p.translate;
		drv_fixed <= fixed;
		drv_want <= want;
		do
			@(posedge clk);
		while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (gate_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic apply_setting(logic [18:0] setting [8]);
		for (int i = 0; i <= REG_MAX_GAP; i++) begin
			cfg_wen <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= setting[i];
			reg_val[i] = (i == REG_MAX_GAP) ? 19'(setting[i][15:0]) : setting[i];
			@(negedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	always @(negedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 19);
	end

	always @(posedge clk) begin : watch
		pass_t seen;
		gate_t due;
		gate_t got;
		if (item_ch.valid && item_ch.ready) begin
			seen = '{item_ch.angle_step, item_ch.period_us, item_ch.time_us, item_ch.time_ms,
				item_ch.speed_rpm, item_ch.steer, item_ch.translate};
			due = heading_gate_pass(seen);
			gate_results_due.push_back(drv_fixed ? drv_want : due);
		end
		if (result_ch.valid && result_ch.ready) begin
			got = '{result_ch.led_on, result_ch.window_active, result_ch.brake_drive,
				result_ch.heading};
			if (gate_results_due.size() == 0) begin
				$display("%0t: result with no request pending, heading %0d", $time, got.heading);
				bad_fields++;
			end else begin
				due = gate_results_due.pop_front();
				if (got.led_on !== due.led_on) begin
					$display("%0t: led_on expected %0d actual %0d", $time, due.led_on, got.led_on);
					bad_fields++;
				end
				if (got.window_active !== due.window_active) begin
					$display("%0t: window_active expected %0d actual %0d", $time,
						due.window_active, got.window_active);
					bad_fields++;
				end
				if (got.brake_drive !== due.brake_drive) begin
					$display("%0t: brake_drive expected %0d actual %0d", $time,
						due.brake_drive, got.brake_drive);
					bad_fields++;
				end
				if (got.heading !== due.heading) begin
					$display("%0t: heading expected %0d actual %0d", $time, due.heading,
						got.heading);
					bad_fields++;
				end
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [18:0] setting [8];
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.angle_step = '0;
		item_ch.period_us = '0;
		item_ch.time_us = '0;
		item_ch.time_ms = '0;
		item_ch.speed_rpm = '0;
		item_ch.steer = '0;
		item_ch.translate = '0;
		result_ch.ready = 1'b0;
		drv_fixed = 1'b0;
		drv_want = '0;
		reg_val[REG_LED_WIDTH] = LED_WIDTH_RST;
		reg_val[REG_ADV_ONE] = '0;
		reg_val[REG_ADV_TWO] = '0;
		reg_val[REG_ADV_THREE] = '0;
		reg_val[REG_ADV_FOUR] = '0;
		reg_val[REG_MIN_PULSE] = MIN_PULSE_RST;
		reg_val[REG_MAX_PULSE] = MAX_PULSE_RST;
		reg_val[REG_MAX_GAP] = 19'(MAX_GAP_RST);
		hdg = '0;
		trim_stamp_us = '0;
		fire_stamp_ms = '0;
		guard_armed = 1'b1;
		arc_was_open = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) begin
				foreach (DIRECTED_ROWS[i])
					send_pass(DIRECTED_ROWS[i].p, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
			end else begin
				drain();
				case (ph)
					1: setting = '{19'd0, 19'd1000, 19'd50000, 19'd120000, 19'd359999,
						19'd0, 19'd360000, 19'd20};
					2: setting = '{default: 19'd0};
					3: setting = '{default: 19'h7FFFF};
					4: setting = '{19'd360000, 19'd360000, 19'd200000, 19'd90000, 19'd30000,
						19'd360000, 19'd0, 19'd1000};
					default: begin
						foreach (setting[i])
							setting[i] = 19'($urandom_range(0, 360000));
						setting[REG_MAX_GAP] = 19'($urandom_range(0, 300));
					end
				endcase
				apply_setting(setting);
			end
			// start the clocks somewhere, now and then just short of the wrap
			clock_us = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000)
				: $urandom;
			clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
				: $urandom;
			for (int n = 0; n < PASSES_PER_PHASE; n++) begin
				// hold requests back until the pipeline has emptied
				if (ph == 2 && n == 45)
					drain();
				calm = (random_sent >= 200 && random_sent < 300);
				send_pass(next_pass(), 1'b0, '0);
				random_sent++;
			end
		end
		calm = 1'b0;

		drain();
		repeat (20) @(negedge clk);
		if (bad_fields == 0 && gate_results_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
